### design/cau_pkg.sv
`default_nettype none
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// opcodes
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_NEG = 3'd4,
		OP_CNJ = 3'd5,
		OP_RCP = 3'd6
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_OVF = 2'd2
	} status_t;

	// control that travels with each word down the pipe
	typedef struct packed {
		logic valid;
		op_t  op;
		logic dz;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
	} ctrl_t;

endpackage
`default_nettype wire

### design/cau_front.sv
`default_nettype none
module cau_front import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic [2:0]             opcode,
	input  wire logic [DATA_WIDTH-1:0]  a_re,
	input  wire logic [DATA_WIDTH-1:0]  a_im,
	input  wire logic [DATA_WIDTH-1:0]  b_re,
	input  wire logic [DATA_WIDTH-1:0]  b_im,
	output ctrl_t                       ctrl_s4,
	output logic [2*DATA_WIDTH+2:0]     e_re_s4,
	output logic [2*DATA_WIDTH+2:0]     e_im_s4,
	output logic [2*DATA_WIDTH+FRAC_BITS+2:0] mag_re_s4,
	output logic [2*DATA_WIDTH+FRAC_BITS+2:0] mag_im_s4,
	output logic [2*DATA_WIDTH+1:0]     den_s4
);

	localparam int W  = DATA_WIDTH;
	localparam int XW = W + 1;
	localparam int PW = 2 * XW;
	localparam int SW = PW + 1;
	localparam int NW = SW + FRAC_BITS;
	localparam int CW = NW + W;

	op_t op_in;
	logic signed [XW-1:0] xr, xi, yr, yi;
	logic signed [SW-1:0] ar_w, ai_w, br_w, bi_w, sr, si;

	ctrl_t ctrl_s1, ctrl_s2, ctrl_s3;
	logic signed [XW-1:0] xr_s1, xi_s1, yr_s1, yi_s1;
	logic signed [SW-1:0] sr_s1, si_s1, sr_s2, si_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [SW-1:0] e_re_s3, e_im_s3;
	logic [PW-1:0] den_s3;

	logic signed [SW-1:0] mul_re, mul_im, div_re, div_im, den_w;
	logic [SW-1:0] abs_re, abs_im;
	logic [NW-1:0] mag_re, mag_im;
	logic [CW-1:0] den_lim;

	assign op_in = op_t'(opcode);

	// operand select: reciprocal divides one by a
	always_comb begin
		ar_w = {{(SW-W){a_re[W-1]}}, a_re};
		ai_w = {{(SW-W){a_im[W-1]}}, a_im};
		br_w = {{(SW-W){b_re[W-1]}}, b_re};
		bi_w = {{(SW-W){b_im[W-1]}}, b_im};
		if (op_in == OP_RCP) begin
			xr = XW'(1) << FRAC_BITS;
			xi = '0;
			yr = {a_re[W-1], a_re};
			yi = {a_im[W-1], a_im};
		end else begin
			xr = {a_re[W-1], a_re};
			xi = {a_im[W-1], a_im};
			yr = {b_re[W-1], b_re};
			yi = {b_im[W-1], b_im};
		end
	end

	// linear operations are done at the input
	always_comb begin
		case (op_in)
			OP_ADD: begin
				sr = ar_w + br_w;
				si = ai_w + bi_w;
			end
			OP_SUB: begin
				sr = ar_w - br_w;
				si = ai_w - bi_w;
			end
			OP_NEG: begin
				sr = -ar_w;
				si = -ai_w;
			end
			OP_CNJ: begin
				sr = ar_w;
				si = -ai_w;
			end
			default: begin
				sr = '0;
				si = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else if (en) begin
			ctrl_s1 <= '{valid: in_valid, op: op_in, default: 1'b0};
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= '{valid: ctrl_s3.valid, op: ctrl_s3.op, dz: (den_s3 == '0),
				neg_re: e_re_s3[SW-1], neg_im: e_im_s3[SW-1],
				ovf_re: (CW'(mag_re) >= den_lim), ovf_im: (CW'(mag_im) >= den_lim)};
		end
	end

	// stage 3 sums
	always_comb begin
		mul_re = {p1_s2[PW-1], p1_s2} - {p2_s2[PW-1], p2_s2};
		mul_im = {p3_s2[PW-1], p3_s2} + {p4_s2[PW-1], p4_s2};
		div_re = {p1_s2[PW-1], p1_s2} + {p2_s2[PW-1], p2_s2};
		div_im = {p4_s2[PW-1], p4_s2} - {p3_s2[PW-1], p3_s2};
		den_w  = {p5_s2[PW-1], p5_s2} + {p6_s2[PW-1], p6_s2};
	end

	// stage 4 magnitudes and quotient range check
	always_comb begin
		abs_re  = e_re_s3[SW-1] ? SW'(-e_re_s3) : SW'(e_re_s3);
		abs_im  = e_im_s3[SW-1] ? SW'(-e_im_s3) : SW'(e_im_s3);
		mag_re  = NW'(abs_re) << FRAC_BITS;
		mag_im  = NW'(abs_im) << FRAC_BITS;
		den_lim = CW'(den_s3) << W;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			xr_s1 <= xr;
			xi_s1 <= xi;
			yr_s1 <= yr;
			yi_s1 <= yi;
			sr_s1 <= sr;
			si_s1 <= si;

			p1_s2 <= xr_s1 * yr_s1;
			p2_s2 <= xi_s1 * yi_s1;
			p3_s2 <= xr_s1 * yi_s1;
			p4_s2 <= xi_s1 * yr_s1;
			p5_s2 <= yr_s1 * yr_s1;
			p6_s2 <= yi_s1 * yi_s1;
			sr_s2 <= sr_s1;
			si_s2 <= si_s1;

			den_s3 <= den_w[PW-1:0];
			case (ctrl_s2.op)
				OP_MUL: begin
					e_re_s3 <= mul_re >>> FRAC_BITS;
					e_im_s3 <= mul_im >>> FRAC_BITS;
				end
				OP_DIV, OP_RCP: begin
					e_re_s3 <= div_re;
					e_im_s3 <= div_im;
				end
				default: begin
					e_re_s3 <= sr_s2;
					e_im_s3 <= si_s2;
				end
			endcase

			e_re_s4   <= e_re_s3;
			e_im_s4   <= e_im_s3;
			mag_re_s4 <= mag_re;
			mag_im_s4 <= mag_im;
			den_s4    <= den_s3;
		end
	end

endmodule
`default_nettype wire

### design/cau_div_step.sv
`default_nettype none
module cau_div_step import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int BIT_POS    = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  ctrl_t                       ctrl_in,
	input  wire logic [2*DATA_WIDTH+2:0] e_re_in,
	input  wire logic [2*DATA_WIDTH+2:0] e_im_in,
	input  wire logic [2*DATA_WIDTH+FRAC_BITS+2:0] rem_re_in,
	input  wire logic [2*DATA_WIDTH+FRAC_BITS+2:0] rem_im_in,
	input  wire logic [2*DATA_WIDTH+1:0] den_in,
	input  wire logic [DATA_WIDTH-1:0]  q_re_in,
	input  wire logic [DATA_WIDTH-1:0]  q_im_in,
	output ctrl_t                       ctrl_sd,
	output logic [2*DATA_WIDTH+2:0]     e_re_sd,
	output logic [2*DATA_WIDTH+2:0]     e_im_sd,
	output logic [2*DATA_WIDTH+FRAC_BITS+2:0] rem_re_sd,
	output logic [2*DATA_WIDTH+FRAC_BITS+2:0] rem_im_sd,
	output logic [2*DATA_WIDTH+1:0]     den_sd,
	output logic [DATA_WIDTH-1:0]       q_re_sd,
	output logic [DATA_WIDTH-1:0]       q_im_sd
);

	localparam int W  = DATA_WIDTH;
	localparam int SW = 2 * W + 3;
	localparam int NW = SW + FRAC_BITS;
	localparam int CW = NW + W;

	logic [CW-1:0] den_sh;
	logic [CW:0] diff_re, diff_im;
	logic [W-1:0] q_re, q_im;

	// one restoring step per lane
	always_comb begin
		den_sh  = CW'(den_in) << BIT_POS;
		diff_re = {1'b0, CW'(rem_re_in)} - {1'b0, den_sh};
		diff_im = {1'b0, CW'(rem_im_in)} - {1'b0, den_sh};
		q_re = q_re_in;
		q_im = q_im_in;
		q_re[BIT_POS] = ~diff_re[CW];
		q_im[BIT_POS] = ~diff_im[CW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_sd <= '0;
		end else if (en) begin
			ctrl_sd <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_re_sd   <= e_re_in;
			e_im_sd   <= e_im_in;
			den_sd    <= den_in;
			q_re_sd   <= q_re;
			q_im_sd   <= q_im;
			rem_re_sd <= diff_re[CW] ? rem_re_in : diff_re[NW-1:0];
			rem_im_sd <= diff_im[CW] ? rem_im_in : diff_im[NW-1:0];
		end
	end

endmodule
`default_nettype wire

### design/cau_back.sv
`default_nettype none
module cau_back import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  ctrl_t                       ctrl_in,
	input  wire logic [2*DATA_WIDTH+2:0] e_re_in,
	input  wire logic [2*DATA_WIDTH+2:0] e_im_in,
	input  wire logic [DATA_WIDTH-1:0]  q_re_in,
	input  wire logic [DATA_WIDTH-1:0]  q_im_in,
	output logic                        out_valid,
	output logic [DATA_WIDTH-1:0]       r_re,
	output logic [DATA_WIDTH-1:0]       r_im,
	output logic [1:0]                  status
);

	localparam int W  = DATA_WIDTH;
	localparam int SW = 2 * W + 3;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic [W:0] sat_re, sat_im;
	logic [W-1:0] res_re, res_im;
	status_t st;

	// clamp a wide signed value, flag in the top bit
	function automatic logic [W:0] sat_wide(input logic [SW-1:0] v);
		logic fits;
		fits = (&v[SW-1:W-1]) | ~(|v[SW-1:W-1]);
		if (fits)
			return {1'b0, v[W-1:0]};
		else
			return {1'b1, v[SW-1] ? MINV : MAXV};
	endfunction

	// sign and clamp a quotient magnitude
	function automatic logic [W:0] sat_quot(input logic neg, input logic big,
			input logic [W-1:0] q);
		logic [W:0] r;
		if (big)
			r = {1'b1, neg ? MINV : MAXV};
		else if (neg)
			r = (q > MINV) ? {1'b1, MINV} : {1'b0, W'(-q)};
		else
			r = q[W-1] ? {1'b1, MAXV} : {1'b0, q};
		return r;
	endfunction

	// result select
	always_comb begin
		sat_re = '0;
		sat_im = '0;
		res_re = '0;
		res_im = '0;
		st     = ST_OK;
		case (ctrl_in.op)
			OP_DIV, OP_RCP: begin
				if (ctrl_in.dz) begin
					st = ST_DZ;
				end else begin
					sat_re = sat_quot(ctrl_in.neg_re, ctrl_in.ovf_re, q_re_in);
					sat_im = sat_quot(ctrl_in.neg_im, ctrl_in.ovf_im, q_im_in);
					res_re = sat_re[W-1:0];
					res_im = sat_im[W-1:0];
					st     = (sat_re[W] | sat_im[W]) ? ST_OVF : ST_OK;
				end
			end
			default: begin
				sat_re = sat_wide(e_re_in);
				sat_im = sat_wide(e_im_in);
				res_re = sat_re[W-1:0];
				res_im = sat_im[W-1:0];
				st     = (sat_re[W] | sat_im[W]) ? ST_OVF : ST_OK;
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctrl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_re   <= res_re;
			r_im   <= res_im;
			status <= st;
		end
	end

endmodule
`default_nettype wire

### design/complex_arithmetic_unit.sv
`default_nettype none
// Complex arithmetic unit on signed fixed point operands (Q16.16 by default):
// add, subtract, multiply, divide, negate, conjugate and reciprocal of a.
// One word is taken per clock unless the output stalls. Each word passes
// through four front stages (operand select, six parallel multipliers,
// sums, magnitude and range check), one restoring divider step per
// quotient bit, and the saturating output register. A stall on the
// output freezes the whole pipe, so in_ready follows out_ready whenever
// the output register is full. A zero divisor gives a zero result with
// divide-by-zero status; a clamped part gives overflow.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [2:0]            opcode,
	input  wire logic [DATA_WIDTH-1:0] a_re,
	input  wire logic [DATA_WIDTH-1:0] a_im,
	input  wire logic [DATA_WIDTH-1:0] b_re,
	input  wire logic [DATA_WIDTH-1:0] b_im,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      r_re,
	output logic [DATA_WIDTH-1:0]      r_im,
	output logic [1:0]                 status
);

	localparam int W  = DATA_WIDTH;
	localparam int SW = 2 * W + 3;
	localparam int NW = SW + FRAC_BITS;
	localparam int PW = 2 * W + 2;

	logic en;

	ctrl_t          ctrl_s [0:W];
	logic [SW-1:0]  e_re_s [0:W];
	logic [SW-1:0]  e_im_s [0:W];
	logic [NW-1:0]  rem_re_s [0:W];
	logic [NW-1:0]  rem_im_s [0:W];
	logic [PW-1:0]  den_s [0:W];
	logic [W-1:0]   q_re_s [0:W];
	logic [W-1:0]   q_im_s [0:W];

	// pipe advances unless a finished word is waiting
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;
	assign q_re_s[0] = '0;
	assign q_im_s[0] = '0;

	cau_front #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.opcode   (opcode),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.ctrl_s4  (ctrl_s[0]),
		.e_re_s4  (e_re_s[0]),
		.e_im_s4  (e_im_s[0]),
		.mag_re_s4(rem_re_s[0]),
		.mag_im_s4(rem_im_s[0]),
		.den_s4   (den_s[0])
	);

	// quotient bits, most significant first
	for (genvar i = 0; i < W; i++) begin : g_div
		cau_div_step #(
			.DATA_WIDTH(DATA_WIDTH),
			.FRAC_BITS (FRAC_BITS),
			.BIT_POS   (W - 1 - i)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctrl_in  (ctrl_s[i]),
			.e_re_in  (e_re_s[i]),
			.e_im_in  (e_im_s[i]),
			.rem_re_in(rem_re_s[i]),
			.rem_im_in(rem_im_s[i]),
			.den_in   (den_s[i]),
			.q_re_in  (q_re_s[i]),
			.q_im_in  (q_im_s[i]),
			.ctrl_sd  (ctrl_s[i+1]),
			.e_re_sd  (e_re_s[i+1]),
			.e_im_sd  (e_im_s[i+1]),
			.rem_re_sd(rem_re_s[i+1]),
			.rem_im_sd(rem_im_s[i+1]),
			.den_sd   (den_s[i+1]),
			.q_re_sd  (q_re_s[i+1]),
			.q_im_sd  (q_im_s[i+1])
		);
	end

	cau_back #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_in  (ctrl_s[W]),
		.e_re_in  (e_re_s[W]),
		.e_im_in  (e_im_s[W]),
		.q_re_in  (q_re_s[W]),
		.q_im_in  (q_im_s[W]),
		.out_valid(out_valid),
		.r_re     (r_re),
		.r_im     (r_im),
		.status   (status)
	);

`ifndef SYNTHESIS
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	// divide by zero always returns a zero word
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DZ |-> r_re == '0 && r_im == '0)
		else $error("divide by zero word is not zero");

	// overflow means at least one part sits at a limit
	a_ovf_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVF |->
			r_re == MAXV || r_re == MINV || r_im == MAXV || r_im == MINV)
		else $error("overflow status without a clamped part");

	// a stalled output word is neither dropped nor replaced
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r_re) && $stable(status))
		else $error("stalled output word changed");
`endif

endmodule
`default_nettype wire

### verif/cau_checker.sv
`timescale 1ns / 100ps
module cau_checker import cau_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [31:0] a_re,
	input  wire logic [31:0] a_im,
	input  wire logic [31:0] b_re,
	input  wire logic [31:0] b_im,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] r_re,
	input  wire logic [31:0] r_im,
	input  wire logic [1:0]  status,
	output int               fail_count,
	output int               pending
);
	localparam int FB = FRAC_BITS_DEF;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  st;
	} cplx_res_t;

	cplx_res_t expected_q[$];

	// clamp a wide value to 32 bits, flag overflow
	function automatic logic [31:0] clamp32(input logic signed [191:0] v, inout logic ovf);
		if (v > 192'sh7fffffff) begin
			ovf = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -192'sh80000000) begin
			ovf = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// signed divide truncated toward zero
	function automatic logic signed [191:0] quot_trunc(input logic signed [191:0] n,
			input logic signed [191:0] d);
		logic signed [191:0] mag;
		logic signed [191:0] q;
		mag = (n < 0) ? -n : n;
		q = mag / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic cplx_res_t predict_word(input logic [2:0] op, input logic [31:0] ar_b,
			input logic [31:0] ai_b, input logic [31:0] br_b, input logic [31:0] bi_b);
		logic signed [191:0] ar, ai, br, bi, re, im, den, nre, nim, lr, li, rr, ri;
		logic ovf;
		cplx_res_t res;
		ar = 192'(signed'(ar_b));
		ai = 192'(signed'(ai_b));
		br = 192'(signed'(br_b));
		bi = 192'(signed'(bi_b));
		re = 0;
		im = 0;
		ovf = 1'b0;
		case (op)
			OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			OP_MUL: begin
				re = (ar * br - ai * bi) >>> FB;
				im = (ar * bi + ai * br) >>> FB;
			end
			OP_DIV, OP_RCP: begin
				if (op == OP_DIV) begin
					lr = ar; li = ai; rr = br; ri = bi;
				end else begin
					lr = 192'sd1 <<< FB; li = 0; rr = ar; ri = ai;
				end
				den = rr * rr + ri * ri;
				if (den == 0) begin
					res.re = '0;
					res.im = '0;
					res.st = ST_DZ;
					return res;
				end
				nre = (lr * rr + li * ri) <<< FB;
				nim = (li * rr - lr * ri) <<< FB;
				re = quot_trunc(nre, den);
				im = quot_trunc(nim, den);
			end
			OP_NEG: begin
				re = -ar;
				im = -ai;
			end
			OP_CNJ: begin
				re = ar;
				im = -ai;
			end
			default: ;
		endcase
		res.re = clamp32(re, ovf);
		res.im = clamp32(im, ovf);
		res.st = ovf ? ST_OVF : ST_OK;
		return res;
	endfunction

	assign pending = expected_q.size();

	// predict on input word, compare on output word
	always @(posedge clk or negedge arst_n) begin
		cplx_res_t exp_w;
		int errs;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			errs = 0;
			if (in_valid && in_ready)
				expected_q.push_back(predict_word(opcode, a_re, a_im, b_re, b_im));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result word re=%h im=%h st=%0d", r_re, r_im, status);
					errs++;
				end else begin
					exp_w = expected_q.pop_front();
					if (r_re !== exp_w.re) begin
						$error("r_re expected %h actual %h", exp_w.re, r_re);
						errs++;
					end
					if (r_im !== exp_w.im) begin
						$error("r_im expected %h actual %h", exp_w.im, r_im);
						errs++;
					end
					if (status !== exp_w.st) begin
						$error("status expected %0d actual %0d", exp_w.st, status);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import cau_pkg::*;

	localparam int N_RANDOM = 1750;
	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] opcode = '0;
	logic [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] r_re, r_im;
	logic [1:0] status;
	int fail_count, pending;
	int idle_cycles = 0;
	bit long_hold = 1'b0;
	bit stim_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	complex_arithmetic_unit dut (.*);

	cau_checker chk (.*);

	// random operand with a bias toward edge values
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h0;
			3: return 32'h00010000;
			4: return 32'hffff0000;
			5: return 32'($signed($urandom_range(0, 255)) - 128) << $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	// offer one word and hold it until taken
	task automatic send_word(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi);
		in_valid <= 1'b1;
		opcode <= op;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 2) == 0) n = 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// receiver stalls, with one long hold-off
	always @(posedge clk) begin
		if (long_hold) begin
			out_ready <= 1'b0;
			repeat (120) @(posedge clk);
			long_hold <= 1'b0;
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 19) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(3, 25)) @(posedge clk);
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog on accepted words
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("[complex_arithmetic_unit] ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] edges[5];
		edges = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h00010000, 32'hffffffff};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: each opcode incl unused, extremes, zero divisors
		for (int op = 0; op < 8; op++)
			send_word(3'(op), 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		send_word(OP_DIV, 32'h00010000, 32'h0, 32'h0, 32'h0);
		send_word(OP_RCP, 32'h0, 32'h0, 32'h5, 32'h5);
		send_word(OP_NEG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
		send_word(OP_CNJ, 32'h1, 32'h80000000, 32'h0, 32'h0);
		send_word(OP_RCP, 32'h1, 32'h0, 32'h0, 32'h0);
		send_word(OP_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0);
		send_word(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		for (int i = 0; i < 5; i++)
			send_word(OP_DIV, edges[i], edges[4 - i], edges[(i + 1) % 5], edges[(i + 3) % 5]);
		send_word(OP_ADD, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		// pause until everything drained
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		// random words, long stall partway through
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) long_hold <= 1'b1;
			send_word(($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
				pick_operand(), pick_operand(), pick_operand(), pick_operand());
			if (i > N_RANDOM / 3 + 80 || i < N_RANDOM / 3) idle_gap();
		end
		in_valid <= 1'b0;
		stim_done <= 1'b1;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[complex_arithmetic_unit] OK");
		else
			$display("[complex_arithmetic_unit] ERROR");
		$finish;
	end
endmodule
